FILE: sv/pba_pkg.sv
// Package for the page bitmap allocator: widths, codes, beat types and states.
package pba_pkg;

    localparam int NUM_GROUPS  = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int PAGE_SHIFT  = 12;
    localparam int NUM_PAGES   = NUM_GROUPS * 64;
    localparam int GROUP_W     = $clog2(NUM_GROUPS);
    localparam int PAGE_W      = GROUP_W + 6;
    localparam int RANGE_W     = PAGE_W + 1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        OP_INIT     = 3'd0,
        OP_FREE_RNG = 3'd1,
        OP_USED_RNG = 3'd2,
        OP_ALLOC    = 3'd3,
        OP_FREE_PG  = 3'd4,
        OP_INC_REF  = 3'd5,
        OP_DEC_REF  = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_IGNORED = 2'd2,
        ST_COUNT   = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] address;
        logic [31:0] extent;
        logic [11:0] page_number;
    } in_beat_t;

    typedef struct packed {
        logic [11:0] result_page;
        logic [1:0]  status;
    } out_beat_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_INIT,
        S_RANGE_RD,
        S_RANGE_WR,
        S_SCAN,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_PAGE_RD,
        S_PAGE_WR,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear_step;
        logic init_step;
        logic range_setup;
        logic range_rd;
        logic range_wr;
        logic scan_setup;
        logic scan_step;
        logic alloc_rd;
        logic alloc_wr;
        logic page_rd;
        logic page_wr;
        logic mark_ignored;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic    clear_last;
        logic    sweep_last;
        logic    range_empty;
        logic    range_last;
        logic    scan_found;
        logic    scan_last;
        logic    page_bad;
        op_t     op;
    } sts_t;

endpackage

FILE: sv/pba_ctrl.sv
// Controller state machine of the page bitmap allocator.
module pba_ctrl import pba_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic out_busy,
    output logic out_load,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (sts.op)
                    OP_INIT: state_next = S_INIT;
                    OP_FREE_RNG, OP_USED_RNG: begin
                        cmd.range_setup = 1'b1;
                        state_next      = S_RANGE_RD;
                    end
                    OP_ALLOC: begin
                        cmd.scan_setup = 1'b1;
                        state_next     = S_SCAN;
                    end
                    OP_FREE_PG, OP_INC_REF, OP_DEC_REF: begin
                        cmd.mark_ignored = sts.page_bad;
                        state_next       = sts.page_bad ? S_DONE : S_PAGE_RD;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.sweep_last) state_next = S_DONE;
            end
            S_RANGE_RD: begin
                if (sts.range_empty) begin
                    state_next = S_DONE;
                end else begin
                    cmd.range_rd = 1'b1;
                    state_next   = S_RANGE_WR;
                end
            end
            S_RANGE_WR: begin
                cmd.range_wr = 1'b1;
                state_next   = sts.range_last ? S_DONE : S_RANGE_RD;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                priority if (sts.scan_found) state_next = S_ALLOC_RD;
                else if (sts.scan_last)     state_next = S_DONE;
                else                        state_next = S_SCAN;
            end
            S_ALLOC_RD: begin
                cmd.alloc_rd = 1'b1;
                state_next   = S_ALLOC_WR;
            end
            S_ALLOC_WR: begin
                cmd.alloc_wr = 1'b1;
                state_next   = S_DONE;
            end
            S_PAGE_RD: begin
                cmd.page_rd = 1'b1;
                state_next  = S_PAGE_WR;
            end
            S_PAGE_WR: begin
                cmd.page_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!out_busy) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

FILE: sv/pba_datapath.sv
// Datapath of the page bitmap allocator: bitmap, count memory and operands.
module pba_datapath import pba_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_beat_t  s_beat,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_beat_t result
);

    logic [63:0]            bitmap_reg [NUM_GROUPS];
    logic [COUNT_WIDTH-1:0] count_mem  [NUM_PAGES];
    logic [COUNT_WIDTH-1:0] count_rd_reg;
    logic [63:0]            grp_rd_reg;

    in_beat_t             beat_reg;
    logic [PAGE_W:0]      sweep_reg;
    logic [RANGE_W-1:0]   cur_reg, last_reg;
    logic [GROUP_W:0]     grp_reg;
    logic [PAGE_W-1:0]    pg_reg;
    logic [1:0]           status_reg;
    logic [11:0]          res_reg;

    logic [32:0] sum_w, end_w;
    logic [33-PAGE_SHIFT:0] ceil_w, first_w;
    logic [RANGE_W-1:0] first_c, last_c;
    logic [31-PAGE_SHIFT:0] apage_w;
    logic [PAGE_W-1:0] cur_pg, tgt_pg;
    logic [GROUP_W-1:0] grp_idx, grp_prev;
    logic [63:0] grp_bits;
    logic [5:0]  low_bit;
    logic        page_bad;
    logic        is_used;

    localparam logic [33-PAGE_SHIFT:0] NP_W = (34 - PAGE_SHIFT)'(NUM_PAGES);

    assign is_used = (beat_reg.operation == OP_USED_RNG);
    assign sum_w   = is_used ? {1'b0, beat_reg.extent}
                             : {1'b0, beat_reg.address} + {1'b0, beat_reg.extent};
    assign end_w   = sum_w;
    assign ceil_w  = (34 - PAGE_SHIFT)'(({1'b0, end_w} + ((34)'(1) << PAGE_SHIFT) - 34'd1)
                     >> PAGE_SHIFT);
    assign first_w = (34 - PAGE_SHIFT)'(beat_reg.address >> PAGE_SHIFT);
    assign first_c = (first_w > NP_W) ? RANGE_W'(NUM_PAGES) : RANGE_W'(first_w);
    assign last_c  = (ceil_w > NP_W) ? RANGE_W'(NUM_PAGES) : RANGE_W'(ceil_w);
    assign apage_w = beat_reg.address[31:PAGE_SHIFT];
    assign cur_pg  = cur_reg[PAGE_W-1:0];

    always_comb begin
        if (beat_reg.operation == OP_FREE_PG) begin
            page_bad = (beat_reg.page_number == 12'd0)
                    || (32'(beat_reg.page_number) >= 32'(NUM_PAGES));
            tgt_pg   = PAGE_W'(beat_reg.page_number);
        end else begin
            page_bad = (apage_w == '0) || (32'(apage_w) >= 32'(NUM_PAGES));
            tgt_pg   = PAGE_W'(apage_w);
        end
    end

    assign grp_idx  = grp_reg[GROUP_W-1:0];
    assign grp_prev = grp_idx - 1'b1;
    assign grp_bits = grp_rd_reg;

    always_comb begin
        low_bit = '0;
        for (int b = 63; b >= 0; b--) begin
            if (!grp_bits[b]) low_bit = 6'(b);
        end
    end

    assign sts.clear_last  = (sweep_reg == (PAGE_W + 1)'(NUM_PAGES - 1));
    assign sts.sweep_last  = (sweep_reg == (PAGE_W + 1)'(NUM_GROUPS - 1));
    assign sts.range_empty = (cur_reg >= last_reg);
    assign sts.range_last  = (cur_reg + RANGE_W'(1) >= last_reg);
    assign sts.scan_found  = (grp_bits != '1);
    assign sts.scan_last   = (grp_reg == '0);
    assign sts.page_bad    = page_bad;
    assign sts.op          = op_t'(beat_reg.operation);

    assign result.result_page = res_reg;
    assign result.status      = status_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            beat_reg   <= s_beat;
            status_reg <= ST_OK;
            res_reg    <= '0;
        end
        if (!aresetn || cmd.load) begin
            sweep_reg <= '0;
        end else if (cmd.clear_step || cmd.init_step) begin
            sweep_reg <= sweep_reg + 1'b1;
        end
        if (cmd.clear_step || cmd.init_step) bitmap_reg[sweep_reg[GROUP_W-1:0]] <= '1;
        if (cmd.range_setup) begin
            cur_reg  <= first_c;
            last_reg <= last_c;
        end
        if (cmd.range_rd) count_rd_reg <= count_mem[cur_pg];
        if (cmd.range_wr) begin
            if (cur_pg != '0) begin
                if (is_used) begin
                    bitmap_reg[cur_pg[PAGE_W-1:6]][cur_pg[5:0]] <= 1'b1;
                    if (count_rd_reg == COUNT_MAX) status_reg <= ST_COUNT;
                    else count_mem[cur_pg] <= count_rd_reg + 1'b1;
                end else begin
                    bitmap_reg[cur_pg[PAGE_W-1:6]][cur_pg[5:0]] <= 1'b0;
                end
            end
            cur_reg <= cur_reg + 1'b1;
        end
        if (cmd.scan_setup) begin
            grp_reg    <= (GROUP_W + 1)'(NUM_GROUPS - 1);
            grp_rd_reg <= bitmap_reg[GROUP_W'(NUM_GROUPS - 1)];
            status_reg <= ST_OOM;
        end
        if (cmd.scan_step) begin
            if (grp_bits != '1) begin
                pg_reg <= {grp_idx, low_bit};
            end else begin
                grp_reg    <= grp_reg - 1'b1;
                grp_rd_reg <= bitmap_reg[grp_prev];
            end
        end
        if (cmd.alloc_rd) count_rd_reg <= count_mem[pg_reg];
        if (cmd.alloc_wr) begin
            bitmap_reg[pg_reg[PAGE_W-1:6]][pg_reg[5:0]] <= 1'b1;
            res_reg <= 12'(pg_reg);
            if (pg_reg == '0) begin
                status_reg <= ST_OK;
            end else if (count_rd_reg == COUNT_MAX) begin
                status_reg <= ST_COUNT;
            end else begin
                status_reg <= ST_OK;
                count_mem[pg_reg] <= count_rd_reg + 1'b1;
            end
        end
        if (cmd.page_rd) count_rd_reg <= count_mem[tgt_pg];
        if (cmd.page_wr) begin
            unique case (beat_reg.operation)
                OP_FREE_PG: begin
                    bitmap_reg[tgt_pg[PAGE_W-1:6]][tgt_pg[5:0]] <= 1'b0;
                    count_mem[tgt_pg] <= '0;
                end
                OP_INC_REF: begin
                    if (count_rd_reg == COUNT_MAX) status_reg <= ST_COUNT;
                    else count_mem[tgt_pg] <= count_rd_reg + 1'b1;
                end
                default: begin
                    if (count_rd_reg == '0) begin
                        status_reg <= ST_COUNT;
                    end else begin
                        count_mem[tgt_pg] <= count_rd_reg - 1'b1;
                        if (count_rd_reg == COUNT_WIDTH'(1))
                            bitmap_reg[tgt_pg[PAGE_W-1:6]][tgt_pg[5:0]] <= 1'b0;
                    end
                end
            endcase
        end
        if (cmd.clear_step) count_mem[sweep_reg[PAGE_W-1:0]] <= '0;
        if (cmd.mark_ignored) status_reg <= ST_IGNORED;
    end

endmodule

FILE: sv/page_bitmap_allocator_refcount.sv
// Top level of the page bitmap allocator with reference counts.
// One operation at a time. After reset a clearing pass over NUM_PAGES (4096)
// pages zeroes the count memory and sets the bitmap; no beat is taken until
// it ends. Alloc checks one group of the bitmap per cycle, highest first.
// Single-page operations do a count memory read then a write step; range
// operations do a read step then a write step per page walked. Results pass
// through a registered result stage.
module page_bitmap_allocator_refcount import pba_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    cmd_t      cmd;
    sts_t      sts;
    out_beat_t res;
    logic      out_load;
    logic      m_valid_reg;
    out_beat_t m_data_reg;

    pba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_busy (m_valid_reg && !m_ready),
        .out_load (out_load),
        .sts      (sts),
        .cmd      (cmd)
    );

    pba_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_beat  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_data_reg <= res;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten while stalled");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat accepted during an operation");

    a_oom_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_OOM) |-> (m_data.result_page == '0))
        else $error("out of memory with a page");

endmodule
